// ===== sv/lir_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the linear-interpolation resampler.
// No dependencies.
package lir_pkg;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE = 2'd2;

  localparam logic [15:0] RATE_MIN   = 16'd4000;
  localparam logic [15:0] RATE_MAX   = 16'd48000;
  localparam logic [15:0] RATE_RESET = 16'd48000;

  localparam logic signed [17:0] SAT_HI = 18'sd32767;
  localparam logic signed [17:0] SAT_LO = -18'sd32768;

  localparam int PHASE_W = 17;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic               final_frame;
  } lir_in_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               run_end;
    logic               stream_end;
  } lir_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LGO,
    ST_LWAIT,
    ST_RGO,
    ST_RWAIT,
    ST_PUSH,
    ST_FINISH
  } lir_state_t;

  typedef enum logic [1:0] {
    IU_IDLE,
    IU_MUL,
    IU_DIV,
    IU_FIN
  } lir_ist_t;

  function automatic logic [15:0] clamp_rate(input logic [15:0] r);
    logic [15:0] v;
    begin
      if (r < RATE_MIN) begin
        v = RATE_MIN;
      end else if (r > RATE_MAX) begin
        v = RATE_MAX;
      end else begin
        v = r;
      end
      return v;
    end
  endfunction

endpackage

// ===== sv/lir_interp.sv =====
`timescale 1ns / 1ps
// Shared interpolation unit: a + ((b - a) * ph) / dv, truncated and saturated.
// One multiply, a 16-step restoring divide, then sign fix and add. Uses lir_pkg.
module lir_interp import lir_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  input  logic [15:0]        ph,
  input  logic [15:0]        dv,
  output logic               done,
  output logic signed [15:0] res
);

  lir_ist_t           state_r, state_nxt;
  logic signed [15:0] a_r, a_nxt;
  logic [15:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [15:0]        ph_r, ph_nxt;
  logic [15:0]        dv_r, dv_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [15:0]        sh_r, sh_nxt;
  logic [3:0]         cnt_r, cnt_nxt;

  logic signed [16:0] diff;
  logic [16:0]        diff_abs;
  logic [31:0]        prod;
  logic [16:0]        trial;
  logic               ge;
  logic signed [17:0] qs;
  logic signed [17:0] sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    a_r   <= a_nxt;
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    ph_r  <= ph_nxt;
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    cnt_r <= cnt_nxt;
  end

  assign diff     = $signed({b[15], b}) - $signed({a[15], a});
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
  assign prod     = mag_r * ph_r;
  assign trial    = {rem_r, sh_r[15]};
  assign ge       = trial >= {1'b0, dv_r};
  assign qs       = neg_r ? -$signed({2'b00, sh_r}) : $signed({2'b00, sh_r});
  assign sum      = $signed({{2{a_r[15]}}, a_r}) + qs;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    ph_nxt    = ph_r;
    dv_nxt    = dv_r;
    rem_nxt   = rem_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    done      = 1'b0;
    res       = sum[15:0];
    if (sum > SAT_HI) begin
      res = SAT_HI[15:0];
    end else if (sum < SAT_LO) begin
      res = SAT_LO[15:0];
    end
    case (state_r)
      IU_IDLE: begin
        if (start) begin
          a_nxt     = a;
          mag_nxt   = diff_abs[15:0];
          neg_nxt   = diff[16];
          ph_nxt    = ph;
          dv_nxt    = dv;
          state_nxt = IU_MUL;
        end
      end
      IU_MUL: begin
        // quotient fits 16 bits, so the high half is already below dv
        rem_nxt   = prod[31:16];
        sh_nxt    = prod[15:0];
        cnt_nxt   = '0;
        state_nxt = IU_DIV;
      end
      IU_DIV: begin
        rem_nxt = ge ? 16'(trial - {1'b0, dv_r}) : trial[15:0];
        sh_nxt  = {sh_r[14:0], ge};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = IU_FIN;
        end
      end
      IU_FIN: begin
        done      = 1'b1;
        state_nxt = IU_IDLE;
      end
      default: begin
        state_nxt = IU_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/linear_interp_resampler_s16.sv =====
`timescale 1ns / 1ps
// Top level of the linear-interpolation resampler for 16-bit PCM frames.
// Uses lir_pkg and lir_interp.
//
// One source frame is taken per input beat and the block then produces every
// output frame that falls before the next source frame, each one interpolated
// by a single shared multiply-and-divide unit (one multiply, a 16-step
// restoring divide, then the add and saturate), used once per channel; at
// most 12 outputs fall in one source interval. The frame marked final also
// flushes the held frame and returns the block to its idle stream state.
// The first frame of a stream only loads the history, unless it is also
// marked final. in_ready is low while an item is in work; the last result of
// an item may still wait in the output register while the next frame is taken.
// run_end marks the last beat caused by each frame and stream_end the last
// beat of a flushed stream.
// Rates are clamped to 4000..48000 Hz when used.
module linear_interp_resampler_s16 import lir_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [15:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lir_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lir_out_t             out_data
);

  logic [15:0] src_cfg_r;
  logic [15:0] dst_cfg_r;
  logic        stereo_r;

  lir_state_t         state_r, state_nxt;
  logic signed [15:0] held_l_r, held_l_nxt;
  logic signed [15:0] held_r_r, held_r_nxt;
  logic               have_r, have_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic signed [15:0] cur_l_r, cur_l_nxt;
  logic signed [15:0] cur_r_r, cur_r_nxt;
  logic               fin_r, fin_nxt;
  logic               flush_r, flush_nxt;
  logic signed [15:0] nres_l_r, nres_l_nxt;
  logic signed [15:0] nres_r_r, nres_r_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic signed [15:0] pend_l_r, pend_l_nxt;
  logic signed [15:0] pend_rt_r, pend_rt_nxt;
  logic               out_valid_r, out_valid_nxt;
  lir_out_t           out_data_r, out_data_nxt;

  logic [15:0]        src_c;
  logic [15:0]        dst_c;
  logic               out_free;
  logic               iu_start;
  logic               iu_done;
  logic signed [15:0] iu_a;
  logic signed [15:0] iu_b;
  logic signed [15:0] iu_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cfg_r <= RATE_RESET;
      dst_cfg_r <= RATE_RESET;
      stereo_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SOURCE_RATE: src_cfg_r <= cfg_wdata;
        CFG_TARGET_RATE: dst_cfg_r <= cfg_wdata;
        CFG_STEREO_MODE: stereo_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 1'b0;
      phase_r     <= '0;
      flush_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      phase_r     <= phase_nxt;
      flush_r     <= flush_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    held_l_r   <= held_l_nxt;
    held_r_r   <= held_r_nxt;
    cur_l_r    <= cur_l_nxt;
    cur_r_r    <= cur_r_nxt;
    fin_r      <= fin_nxt;
    nres_l_r   <= nres_l_nxt;
    nres_r_r   <= nres_r_nxt;
    pend_l_r   <= pend_l_nxt;
    pend_rt_r  <= pend_rt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign src_c    = clamp_rate(src_cfg_r);
  assign dst_c    = clamp_rate(dst_cfg_r);
  assign out_free = !out_valid_r || out_ready;
  assign iu_a     = (state_r == ST_RGO) ? held_r_r : held_l_r;
  assign iu_b     = (state_r == ST_RGO) ? cur_r_r : cur_l_r;

  lir_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (iu_start),
    .a     (iu_a),
    .b     (iu_b),
    .ph    (phase_r[15:0]),
    .dv    (dst_c),
    .done  (iu_done),
    .res   (iu_res)
  );

  always_comb begin
    state_nxt     = state_r;
    held_l_nxt    = held_l_r;
    held_r_nxt    = held_r_r;
    have_nxt      = have_r;
    phase_nxt     = phase_r;
    cur_l_nxt     = cur_l_r;
    cur_r_nxt     = cur_r_r;
    fin_nxt       = fin_r;
    flush_nxt     = flush_r;
    nres_l_nxt    = nres_l_r;
    nres_r_nxt    = nres_r_r;
    pend_v_nxt    = pend_v_r;
    pend_l_nxt    = pend_l_r;
    pend_rt_nxt   = pend_rt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    iu_start      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cur_l_nxt = in_data.left_in;
          cur_r_nxt = stereo_r ? in_data.right_in : 16'sd0;
          fin_nxt   = in_data.final_frame;
          flush_nxt = 1'b0;
          if (have_r) begin
            state_nxt = ST_CHECK;
          end else begin
            held_l_nxt = in_data.left_in;
            held_r_nxt = stereo_r ? in_data.right_in : 16'sd0;
            have_nxt   = 1'b1;
            if (in_data.final_frame) begin
              flush_nxt = 1'b1;
              state_nxt = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        if (phase_r < {1'b0, dst_c}) begin
          if (flush_r) begin
            nres_l_nxt = held_l_r;
            nres_r_nxt = held_r_r;
            state_nxt  = ST_PUSH;
          end else begin
            state_nxt = ST_LGO;
          end
        end else if (flush_r) begin
          held_l_nxt = '0;
          held_r_nxt = '0;
          have_nxt   = 1'b0;
          phase_nxt  = '0;
          state_nxt  = ST_FINISH;
        end else begin
          phase_nxt  = phase_r - {1'b0, dst_c};
          held_l_nxt = cur_l_r;
          held_r_nxt = cur_r_r;
          have_nxt   = 1'b1;
          if (fin_r) begin
            flush_nxt = 1'b1;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_LGO: begin
        iu_start  = 1'b1;
        state_nxt = ST_LWAIT;
      end
      ST_LWAIT: begin
        if (iu_done) begin
          nres_l_nxt = iu_res;
          if (stereo_r) begin
            state_nxt = ST_RGO;
          end else begin
            nres_r_nxt = '0;
            state_nxt  = ST_PUSH;
          end
        end
      end
      ST_RGO: begin
        iu_start  = 1'b1;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (iu_done) begin
          nres_r_nxt = iu_res;
          state_nxt  = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // the held result goes out once a later one exists, so run_end is known
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{left_out: pend_l_r, right_out: pend_rt_r,
                              run_end: 1'b0, stream_end: 1'b0};
          end
          pend_v_nxt  = 1'b1;
          pend_l_nxt  = nres_l_r;
          pend_rt_nxt = nres_r_r;
          phase_nxt   = PHASE_W'(phase_r + {1'b0, src_c});
          state_nxt   = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{left_out: pend_l_r, right_out: pend_rt_r,
                            run_end: 1'b1, stream_end: fin_r};
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
